FILE: rtl/core/xcpf_pkg.sv
package xcpf_pkg;

    // Input command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEADER_MARKER = 2'd0;
    localparam logic [1:0] REG_BODY_MARKER   = 2'd1;
    localparam logic [1:0] REG_END_MARKER    = 2'd2;
    localparam logic [1:0] REG_RAW_CODE      = 2'd3;

    // The length field counts the nine framing bytes as well.
    localparam logic [15:0] LEN_OVERHEAD = 16'd9;

    // Queue between the front and back parts.
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef enum logic {
        K_START,
        K_DATA
    } t_kind;

    // One classified job for the back part.
    typedef struct packed {
        t_kind       kind;
        logic        last;   // Packet ends after this job.
        logic        check;  // Data byte enters the checksum.
        logic [7:0]  b0;     // First command byte, or the data byte.
        logic [7:0]  b1;     // Second command byte.
        logic [15:0] total;  // Total packet length.
    } t_entry;

    typedef struct packed {
        logic [7:0] header_marker;
        logic [7:0] body_marker;
        logic [7:0] end_marker;
    } t_cfg;

endpackage

FILE: rtl/core/xcpf_front.sv
module xcpf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_command,
    input  logic [7:0]     i_first_command,
    input  logic [7:0]     i_second_command,
    input  logic [15:0]    i_payload_length,
    input  logic [7:0]     i_data_byte,
    input  logic [7:0]     i_raw_command_code,
    input  logic           i_fifo_full,
    output logic           o_push,
    output xcpf_pkg::t_entry o_entry
);
    import xcpf_pkg::*;

    logic        r_open;
    logic [15:0] r_left;
    logic        r_unchecked;
    logic        w_accept;

    assign o_in_ready = !i_fifo_full;
    assign w_accept   = i_in_valid && !i_fifo_full;

    // Payload bytes with no open packet are dropped here.
    assign o_push = w_accept && ((i_command == CMD_START) || r_open);

    always_comb begin
        o_entry.b1    = i_second_command;
        o_entry.total = i_payload_length + LEN_OVERHEAD;
        if (i_command == CMD_START) begin
            o_entry.kind  = K_START;
            o_entry.last  = (i_payload_length == 16'd0);
            o_entry.check = 1'b0;
            o_entry.b0    = i_first_command;
        end else begin
            o_entry.kind  = K_DATA;
            o_entry.last  = (r_left == 16'd1);
            o_entry.check = !r_unchecked;
            o_entry.b0    = i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_left      <= 16'd0;
            r_unchecked <= 1'b0;
        end else if (w_accept) begin
            if (i_command == CMD_START) begin
                r_open      <= (i_payload_length != 16'd0);
                r_left      <= i_payload_length;
                r_unchecked <= (i_second_command == i_raw_command_code);
            end else if (r_open) begin
                r_open <= (r_left != 16'd1);
                r_left <= r_left - 16'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_left != 16'd0))
        else $error("open packet with no bytes left");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_fifo_full)
        else $error("push into full queue");
    a_drop_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_DATA) && !r_open) |-> !o_push)
        else $error("orphan payload byte was queued");
`endif

endmodule

FILE: rtl/core/xcpf_fifo.sv
module xcpf_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  xcpf_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output xcpf_pkg::t_entry o_entry
);
    import xcpf_pkg::*;

    t_entry             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/xcpf_back.sv
module xcpf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xcpf_pkg::t_cfg   i_cfg,
    input  logic             i_empty,
    input  xcpf_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_packet
);
    import xcpf_pkg::*;

    localparam logic [3:0] STEP_MARK   = 4'd0;
    localparam logic [3:0] STEP_ZERO   = 4'd1;
    localparam logic [3:0] STEP_LEN_LO = 4'd2;
    localparam logic [3:0] STEP_LEN_HI = 4'd3;
    localparam logic [3:0] STEP_CMD1   = 4'd4;
    localparam logic [3:0] STEP_CMD2   = 4'd5;
    localparam logic [3:0] STEP_BODY   = 4'd6;
    localparam logic [3:0] STEP_END    = 4'd7;
    localparam logic [3:0] STEP_SUM    = 4'd8;

    logic [3:0] r_step;
    logic [7:0] r_xor;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       w_free;
    logic       w_go;
    logic       w_start;
    logic [7:0] w_byte;
    logic [7:0] n_xor;
    logic [3:0] n_step;

    assign w_free  = !r_out_valid || i_out_ready;
    assign w_go    = !i_empty && w_free;
    assign w_start = (i_entry.kind == K_START);

    // A start job walks steps 0 to 6 (and 7, 8 for an empty packet); a data
    // job emits at step 0 and jumps to the trailer steps when it ends the packet.
    always_comb begin
        case (r_step)
            STEP_MARK:   w_byte = w_start ? i_cfg.header_marker : i_entry.b0;
            STEP_ZERO:   w_byte = 8'h00;
            STEP_LEN_LO: w_byte = i_entry.total[7:0];
            STEP_LEN_HI: w_byte = i_entry.total[15:8];
            STEP_CMD1:   w_byte = i_entry.b0;
            STEP_CMD2:   w_byte = i_entry.b1;
            STEP_BODY:   w_byte = i_cfg.body_marker;
            STEP_END:    w_byte = i_cfg.end_marker;
            STEP_SUM:    w_byte = i_cfg.end_marker ^ r_xor;
            default:     w_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_xor = r_xor;
        if (r_step == STEP_MARK) begin
            if (w_start) begin
                n_xor = w_byte;
            end else if (i_entry.check) begin
                n_xor = r_xor ^ w_byte;
            end
        end else if (r_step <= STEP_BODY) begin
            n_xor = r_xor ^ w_byte;
        end
    end

    always_comb begin
        o_pop  = 1'b0;
        n_step = r_step + 4'd1;
        if (w_go) begin
            if (r_step == STEP_SUM) begin
                o_pop = 1'b1;
            end else if (!i_entry.last &&
                         ((w_start && r_step == STEP_BODY) ||
                          (!w_start && r_step == STEP_MARK))) begin
                o_pop = 1'b1;
            end
            if (!w_start && r_step == STEP_MARK) begin
                n_step = STEP_END;
            end
            if (o_pop) begin
                n_step = STEP_MARK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_MARK;
            r_xor       <= 8'h00;
            r_out_valid <= 1'b0;
            r_out_byte  <= 8'h00;
            r_out_last  <= 1'b0;
        end else if (w_go) begin
            r_step      <= n_step;
            r_xor       <= n_xor;
            r_out_valid <= 1'b1;
            r_out_byte  <= w_byte;
            r_out_last  <= (r_step == STEP_SUM);
        end else if (w_free) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_packet = r_out_last;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_SUM)
        else $error("step counter out of range");
    a_data_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !w_start) |->
            (r_step == STEP_MARK || r_step == STEP_END || r_step == STEP_SUM))
        else $error("data job at a header step");
    a_last_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_step == STEP_SUM) |=> (o_out_valid && o_last_of_packet))
        else $error("checksum byte not marked last");
`endif

endmodule

FILE: rtl/core/xor_checked_command_packet_framer.sv
// The first byte of a start or payload item passes through the queue and the output
// register before it is valid, when the queue is empty and the output is free.
// One output byte per cycle while the output is ready and a job waits; a payload item
// gives one byte, a start seven (nine for an empty packet); ending a packet adds two more.
// Reset (synchronous, active low) clears the registers, the packet state and the queue.
module xor_checked_command_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_first_command,
    input  logic [7:0]  i_second_command,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    // Output byte channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_packet,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import xcpf_pkg::*;

    // The front part tracks the open packet and turns every accepted start, and every
    // payload item of an open packet, into a job; the back part expands jobs into bytes
    // and keeps the running checksum. A four-entry queue sits between them so a stalled
    // output does not stop the input until the queue fills.

    t_cfg       r_cfg;
    logic [7:0] r_raw_code;

    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_entry     w_front_entry;
    t_entry     w_back_entry;

    // Configuration transfers are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '0;
            r_raw_code <= 8'h00;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEADER_MARKER: r_cfg.header_marker <= i_cfg_data;
                REG_BODY_MARKER:   r_cfg.body_marker   <= i_cfg_data;
                REG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data;
                REG_RAW_CODE:      r_raw_code          <= i_cfg_data;
                default:           r_raw_code          <= r_raw_code;
            endcase
        end
    end

    xcpf_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_first_command    (i_first_command),
        .i_second_command   (i_second_command),
        .i_payload_length   (i_payload_length),
        .i_data_byte        (i_data_byte),
        .i_raw_command_code (r_raw_code),
        .i_fifo_full        (w_full),
        .o_push             (w_push),
        .o_entry            (w_front_entry)
    );

    xcpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_entry (w_back_entry)
    );

    xcpf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_empty          (w_empty),
        .i_entry          (w_back_entry),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_packet (o_last_of_packet)
    );

endmodule
